FILE: sv/cse_pkg.sv
// cse_pkg: shared widths, constants, register and mode codes, fsm states and
// the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package cse_pkg;

  localparam int NR_MAX    = 32;
  localparam int NT_MAX    = 256;
  localparam int NP_MAX    = 256;

  localparam int COEF_W    = 32;
  localparam int BASIS_W   = 32;
  localparam int VAL_W     = 40;
  localparam int ACC_W     = 48;
  localparam int TH_W      = 8;
  localparam int PHI_W     = 9;
  localparam int RCNT_W    = 6;
  localparam int TCNT_W    = 9;
  localparam int PCNT_W    = 9;
  localparam int RPOS_W    = 5;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int TBL_DEPTH = 2 * NR_MAX;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  // 1.0 in q1.30
  localparam logic signed [BASIS_W-1:0] ONE_Q30 = 32'sh4000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RCNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TCNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PCNT  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FULL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EVEN     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ODD      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PHI_EVEN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PHI_ODD  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TH_EVEN  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TH_ODD   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL0,
    ST_FILL1,
    ST_FMUL,
    ST_FADD,
    ST_LOOK,
    ST_MUL,
    ST_ACC
  } cse_state_e;

  typedef struct packed {
    logic load;       // latch the accepted coefficient
    logic fill0;      // write T_0
    logic fill1;      // write T_1, mark table ready
    logic fill_mul;   // x * T_(n-1)
    logic fill_step;  // finish T_n and write it
    logic look;       // table read for this coefficient
    logic mul;        // coefficient * basis
    logic acc;        // accumulate and advance positions
  } cse_cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_end;
    logic emit;       // this word closes a row that gives a result
    logic out_block;  // such a row while the output register is still held
  } cse_stat_t;

endpackage

FILE: sv/cse_if.sv
// cse_if: valid/ready channels for coefficients, row results and register writes.
// Depends on cse_pkg.
`timescale 1ns / 1ps

interface cse_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cse_pkg::COEF_W-1:0]   coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface

interface cse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cse_pkg::VAL_W-1:0]    row_value;
  logic        [cse_pkg::TH_W-1:0]     theta_index;
  logic        [cse_pkg::PHI_W-1:0]    phi_index;
  logic                                last_row;

  modport source (output valid, output row_value, output theta_index,
                  output phi_index, output last_row, input ready);
  modport sink   (input valid, input row_value, input theta_index,
                  input phi_index, input last_row, output ready);
endinterface

interface cse_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cse_pkg::CFG_IDX_W-1:0]       reg_index;
  logic [cse_pkg::CFG_DAT_W-1:0]       reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

FILE: sv/cse_ram.sv
// cse_ram: generic single-write, single-read ram with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: sv/cse_ctrl.sv
// cse_ctrl: sequencer for table fill and the per-coefficient read, multiply,
// accumulate steps. Depends on cse_pkg.
`timescale 1ns / 1ps

module cse_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cse_pkg::cse_stat_t  stat_i,
  output cse_pkg::cse_cmd_t   cmd_o,
  output cse_pkg::cse_state_e state_o
);

  cse_pkg::cse_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.need_fill ? cse_pkg::ST_FILL0 : cse_pkg::ST_LOOK;
        end
      end
      cse_pkg::ST_FILL0: state_d = cse_pkg::ST_FILL1;
      cse_pkg::ST_FILL1: state_d = stat_i.fill_end ? cse_pkg::ST_LOOK : cse_pkg::ST_FMUL;
      cse_pkg::ST_FMUL:  state_d = cse_pkg::ST_FADD;
      cse_pkg::ST_FADD:  state_d = stat_i.fill_end ? cse_pkg::ST_LOOK : cse_pkg::ST_FMUL;
      cse_pkg::ST_LOOK:  state_d = cse_pkg::ST_MUL;
      cse_pkg::ST_MUL:   state_d = cse_pkg::ST_ACC;
      cse_pkg::ST_ACC: begin
        if (!stat_i.out_block) begin
          state_d = cse_pkg::ST_IDLE;
        end
      end
      default: state_d = cse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cse_pkg::ST_FILL0: cmd_o.fill0     = 1'b1;
      cse_pkg::ST_FILL1: cmd_o.fill1     = 1'b1;
      cse_pkg::ST_FMUL:  cmd_o.fill_mul  = 1'b1;
      cse_pkg::ST_FADD:  cmd_o.fill_step = 1'b1;
      cse_pkg::ST_LOOK:  cmd_o.look      = 1'b1;
      cse_pkg::ST_MUL:   cmd_o.mul       = 1'b1;
      cse_pkg::ST_ACC:   cmd_o.acc       = !stat_i.out_block;
      default: cmd_o = '0;
    endcase
  end

  assign state_o = state_q;

endmodule

FILE: sv/cse_dp.sv
// cse_dp: configuration registers, basis table, shared multiplier, row
// accumulator, position counters and output register.
// Depends on cse_pkg, cse_if and cse_ram.
`timescale 1ns / 1ps

module cse_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cse_pkg::cse_cmd_t                   cmd_i,
  output cse_pkg::cse_stat_t                  stat_o,
  input  logic signed [cse_pkg::COEF_W-1:0]   coefficient_i,
  cse_cfg_if.sink                             cfg,
  cse_out_if.source                           res
);

  // configuration
  logic [cse_pkg::MODE_W-1:0]         mode_q;
  logic signed [cse_pkg::BASIS_W-1:0] x_q;
  logic [cse_pkg::RCNT_W-1:0]         rcnt_q;
  logic [cse_pkg::TCNT_W-1:0]         tcnt_q;
  logic [cse_pkg::PCNT_W-1:0]         pcnt_q;

  // set state
  logic                               tbl_ok_q;
  logic signed [cse_pkg::ACC_W-1:0]   acc_q;
  logic [cse_pkg::RPOS_W-1:0]         rpos_q;
  logic [cse_pkg::TH_W-1:0]           tpos_q;
  logic [cse_pkg::PHI_W-1:0]          ppos_q;

  // working registers
  logic signed [cse_pkg::COEF_W-1:0]  coef_q;
  logic signed [cse_pkg::BASIS_W-1:0] t0_q, t1_q;
  logic signed [63:0]                 prod_q, prod_d;
  logic [cse_pkg::TBL_AW-1:0]         fill_n_q;

  logic                               out_valid_q;
  logic signed [cse_pkg::VAL_W-1:0]   out_val_q;
  logic [cse_pkg::TH_W-1:0]           out_th_q;
  logic [cse_pkg::PHI_W-1:0]          out_phi_q;
  logic                               out_last_q;

  logic                               cfg_wr, restart_cfg;
  logic [cse_pkg::RCNT_W-1:0]         r_eff;
  logic [cse_pkg::TCNT_W-1:0]         nt_eff;
  logic [cse_pkg::PCNT_W-1:0]         np_eff, last_block;
  logic [cse_pkg::TBL_AW-1:0]         tbl_idx, i2;
  logic [cse_pkg::TBL_AW-1:0]         waddr;
  logic signed [cse_pkg::BASIS_W-1:0] wdata, rdata, fsat;
  logic                               we;
  logic signed [cse_pkg::BASIS_W-1:0] mul_a, mul_b;
  logic signed [63:0]                 rnd_fill, rnd_term;
  logic signed [34:0]                 ft;
  logic signed [35:0]                 fdiff;
  logic signed [33:0]                 term;
  logic signed [cse_pkg::ACC_W:0]     acc_sum;
  logic signed [cse_pkg::ACC_W-1:0]   acc_sat, acc_new;
  logic signed [cse_pkg::VAL_W-1:0]   val_sat;
  logic                               row_end, theta_end, set_end, skip, last;
  logic [cse_pkg::PHI_W:0]            phi_next;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_comb begin
    restart_cfg = 1'b0;
    case (cfg.reg_index)
      cse_pkg::REG_MODE, cse_pkg::REG_POINT, cse_pkg::REG_RCNT,
      cse_pkg::REG_TCNT, cse_pkg::REG_PCNT: restart_cfg = cfg_wr;
      default: restart_cfg = 1'b0;
    endcase
  end

  // effective counts
  always_comb begin
    if (rcnt_q == '0) begin
      r_eff = cse_pkg::RCNT_W'(1);
    end else if (rcnt_q > cse_pkg::RCNT_W'(cse_pkg::NR_MAX)) begin
      r_eff = cse_pkg::RCNT_W'(cse_pkg::NR_MAX);
    end else begin
      r_eff = rcnt_q;
    end
    if (tcnt_q == '0) begin
      nt_eff = cse_pkg::TCNT_W'(1);
    end else if (tcnt_q > cse_pkg::TCNT_W'(cse_pkg::NT_MAX)) begin
      nt_eff = cse_pkg::TCNT_W'(cse_pkg::NT_MAX);
    end else begin
      nt_eff = tcnt_q;
    end
    if (pcnt_q == '0) begin
      np_eff = cse_pkg::PCNT_W'(1);
    end else if (pcnt_q > cse_pkg::PCNT_W'(cse_pkg::NP_MAX)) begin
      np_eff = cse_pkg::PCNT_W'(cse_pkg::NP_MAX);
    end else begin
      np_eff = pcnt_q;
    end
    last_block = (np_eff > cse_pkg::PCNT_W'(1)) ? np_eff : '0;
  end

  // basis index for this radial position
  assign i2 = {rpos_q, 1'b0};
  always_comb begin
    case (mode_q)
      cse_pkg::MODE_EVEN:     tbl_idx = i2;
      cse_pkg::MODE_ODD:      tbl_idx = i2 | cse_pkg::TBL_AW'(1);
      cse_pkg::MODE_PHI_EVEN: tbl_idx = i2 | cse_pkg::TBL_AW'(ppos_q[1]);
      cse_pkg::MODE_PHI_ODD:  tbl_idx = i2 | cse_pkg::TBL_AW'(!ppos_q[1]);
      cse_pkg::MODE_TH_EVEN:  tbl_idx = i2 | cse_pkg::TBL_AW'(tpos_q[0]);
      cse_pkg::MODE_TH_ODD:   tbl_idx = i2 | cse_pkg::TBL_AW'(!tpos_q[0]);
      default:                tbl_idx = cse_pkg::TBL_AW'(rpos_q);
    endcase
  end

  // shared multiplier
  assign mul_a  = cmd_i.fill_mul ? x_q  : coef_q;
  assign mul_b  = cmd_i.fill_mul ? t1_q : rdata;
  assign prod_d = mul_a * mul_b;

  // recurrence: round(2 x T_(n-1)) - T_(n-2), saturated
  assign rnd_fill = prod_q + 64'sd268435456;
  assign ft       = rnd_fill[63:29];
  assign fdiff    = {ft[34], ft} - {{4{t0_q[31]}}, t0_q};
  always_comb begin
    if (fdiff[35:31] == '0 || fdiff[35:31] == '1) begin
      fsat = fdiff[31:0];
    end else begin
      fsat = fdiff[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  // rounded product into the accumulator
  assign rnd_term = prod_q + 64'sd536870912;
  assign term     = rnd_term[63:30];
  assign acc_sum  = {acc_q[cse_pkg::ACC_W-1], acc_q} + {{15{term[33]}}, term};
  always_comb begin
    if (acc_sum[cse_pkg::ACC_W] == acc_sum[cse_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[cse_pkg::ACC_W-1:0];
    end else begin
      acc_sat = acc_sum[cse_pkg::ACC_W] ? {1'b1, {(cse_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(cse_pkg::ACC_W-1){1'b1}}};
    end
  end
  assign acc_new = skip ? acc_q : acc_sat;
  always_comb begin
    if (acc_new[cse_pkg::ACC_W-1:cse_pkg::VAL_W-1] == '0 ||
        acc_new[cse_pkg::ACC_W-1:cse_pkg::VAL_W-1] == '1) begin
      val_sat = acc_new[cse_pkg::VAL_W-1:0];
    end else begin
      val_sat = acc_new[cse_pkg::ACC_W-1] ? {1'b1, {(cse_pkg::VAL_W-1){1'b0}}}
                                          : {1'b0, {(cse_pkg::VAL_W-1){1'b1}}};
    end
  end

  // position bookkeeping
  assign skip      = (ppos_q == cse_pkg::PHI_W'(1));
  assign row_end   = ({1'b0, rpos_q} + cse_pkg::RCNT_W'(1)) >= r_eff;
  assign theta_end = ({1'b0, tpos_q} + cse_pkg::TCNT_W'(1)) >= nt_eff;
  assign phi_next  = {1'b0, ppos_q} + (cse_pkg::PHI_W+1)'(1);
  assign set_end   = phi_next > {1'b0, last_block};
  assign last      = (ppos_q == last_block) && theta_end;

  assign stat_o.need_fill = !tbl_ok_q;
  assign stat_o.fill_end  = ({1'b0, fill_n_q} + (cse_pkg::TBL_AW+1)'(1)) >= {r_eff, 1'b0};
  assign stat_o.emit      = row_end && !skip;
  assign stat_o.out_block = row_end && !skip && out_valid_q && !res.ready;

  // basis table
  assign we    = cmd_i.fill0 || cmd_i.fill1 || cmd_i.fill_step;
  assign waddr = cmd_i.fill0 ? '0 : fill_n_q;
  assign wdata = cmd_i.fill0 ? cse_pkg::ONE_Q30 : (cmd_i.fill1 ? x_q : fsat);

  cse_ram #(
    .WIDTH(cse_pkg::BASIS_W),
    .DEPTH(cse_pkg::TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.look),
    .raddr_i (tbl_idx),
    .rdata_o (rdata)
  );

  // configuration and set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= cse_pkg::MODE_FULL;
      x_q      <= '0;
      rcnt_q   <= cse_pkg::RCNT_W'(1);
      tcnt_q   <= cse_pkg::TCNT_W'(1);
      pcnt_q   <= cse_pkg::PCNT_W'(1);
      tbl_ok_q <= 1'b0;
      acc_q    <= '0;
      rpos_q   <= '0;
      tpos_q   <= '0;
      ppos_q   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg.reg_index)
          cse_pkg::REG_MODE:  mode_q <= cfg.reg_data[cse_pkg::MODE_W-1:0];
          cse_pkg::REG_POINT: x_q    <= cfg.reg_data[cse_pkg::BASIS_W-1:0];
          cse_pkg::REG_RCNT:  rcnt_q <= cfg.reg_data[cse_pkg::RCNT_W-1:0];
          cse_pkg::REG_TCNT:  tcnt_q <= cfg.reg_data[cse_pkg::TCNT_W-1:0];
          cse_pkg::REG_PCNT:  pcnt_q <= cfg.reg_data[cse_pkg::PCNT_W-1:0];
          default: ;
        endcase
      end
      if (restart_cfg) begin
        tbl_ok_q <= 1'b0;
        acc_q    <= '0;
        rpos_q   <= '0;
        tpos_q   <= '0;
        ppos_q   <= '0;
      end else if (cmd_i.fill1) begin
        tbl_ok_q <= 1'b1;
        acc_q    <= '0;
      end else if (cmd_i.acc) begin
        if (row_end) begin
          acc_q  <= '0;
          rpos_q <= '0;
          if (theta_end) begin
            tpos_q <= '0;
            if (set_end) begin
              ppos_q   <= '0;
              tbl_ok_q <= 1'b0;
            end else begin
              ppos_q <= phi_next[cse_pkg::PHI_W-1:0];
            end
          end else begin
            tpos_q <= tpos_q + cse_pkg::TH_W'(1);
          end
        end else begin
          acc_q  <= acc_new;
          rpos_q <= rpos_q + cse_pkg::RPOS_W'(1);
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coef_q <= coefficient_i;
    end
    if (cmd_i.fill_mul || cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fill0) begin
      t0_q     <= cse_pkg::ONE_Q30;
      fill_n_q <= cse_pkg::TBL_AW'(1);
    end else if (cmd_i.fill1) begin
      t1_q     <= x_q;
      fill_n_q <= cse_pkg::TBL_AW'(2);
    end else if (cmd_i.fill_step) begin
      t0_q     <= t1_q;
      t1_q     <= fsat;
      fill_n_q <= fill_n_q + cse_pkg::TBL_AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.acc && row_end && !skip) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && row_end && !skip) begin
      out_val_q  <= val_sat;
      out_th_q   <= tpos_q;
      out_phi_q  <= ppos_q;
      out_last_q <= last;
    end
  end

  assign res.valid       = out_valid_q;
  assign res.row_value   = out_val_q;
  assign res.theta_index = out_th_q;
  assign res.phi_index   = out_phi_q;
  assign res.last_row    = out_last_q;

endmodule

FILE: sv/chebyshev_series_row_evaluator.sv
// chebyshev_series_row_evaluator: Chebyshev series row sums over a coefficient stream.
// A word is accepted in idle, then goes through table read, shared multiply and accumulate;
// result valid the next cycle. A new coefficient is taken only after the accumulate, which
// stalls on a held result. A set's first word adds a 2R-entry table fill, R the radial count.
// Reset clears control state and loads register reset values; the table needs no clearing.
`timescale 1ns / 1ps

module chebyshev_series_row_evaluator (
  input  logic      clk_i,
  input  logic      rst_ni,
  cse_in_if.sink    in_chan_i,
  cse_out_if.source out_chan_o,
  cse_cfg_if.sink   cfg_chan_i
);

  cse_pkg::cse_cmd_t   cmd;
  cse_pkg::cse_stat_t  stat;
  cse_pkg::cse_state_e state;

  cse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  cse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .coefficient_i (in_chan_i.coefficient),
    .cfg           (cfg_chan_i),
    .res           (out_chan_o)
  );

  // table writes happen only while filling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fill0 || cmd.fill1 || cmd.fill_step) |->
      (state == cse_pkg::ST_FILL0 || state == cse_pkg::ST_FILL1 ||
       state == cse_pkg::ST_FADD))
    else $error("table write outside fill");

  // a new row result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.acc && stat.emit) |-> !(out_chan_o.valid && !out_chan_o.ready))
    else $error("row result overwritten");

  // with the table filled, an accepted word goes straight to the table read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan_i.valid && in_chan_i.ready && !stat.need_fill) |=>
      (state == cse_pkg::ST_LOOK))
    else $error("table read skipped");

  // skipped phi block never shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan_o.valid |-> (out_chan_o.phi_index != cse_pkg::PHI_W'(1)))
    else $error("result from skipped phi block");

endmodule
